FILE: rtl/nsh_pkg.sv
`default_nettype none

package nsh_pkg;

  localparam int SPHERE_SLOTS = 64;
  localparam int IDX_W = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1;
  localparam int CNT_W = $clog2(SPHERE_SLOTS + 1);
  localparam logic [30:0] MAX_DISTANCE_RESET = 31'd65536000;
  localparam int HB_W = 37;
  localparam int ROOT_W = 36;
  localparam int DISC_W = 2 * ROOT_W;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  typedef enum logic [1:0] {
    ST_LOADED = 2'd0,
    ST_FULL   = 2'd1,
    ST_HIT    = 2'd2,
    ST_MISS   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_DIFF,
    S_MUL,
    S_SUM,
    S_HB,
    S_DISC,
    S_SQRT,
    S_ROOT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        rad;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } sphere_entry_t;

  typedef struct packed {
    logic [35:0] hh;
    logic [35:0] hl;
    logic [35:0] ll;
  } sq_parts_t;

  function automatic logic [35:0] mag37(input logic signed [HB_W-1:0] v);
    logic signed [HB_W-1:0] n;
    n = -v;
    return v[HB_W-1] ? n[35:0] : v[35:0];
  endfunction

  // The square of a 36-bit magnitude is split into three 18 by 18 products.
  function automatic sq_parts_t sq_split(input logic [35:0] a);
    sq_parts_t p;
    p.hh = a[35:18] * a[35:18];
    p.hl = a[35:18] * a[17:0];
    p.ll = a[17:0] * a[17:0];
    return p;
  endfunction

  function automatic logic [DISC_W-1:0] sq_join(input sq_parts_t p);
    return {p.hh, 36'd0} + (DISC_W'(p.hl) << 19) + DISC_W'(p.ll);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nearest_sphere_hit_top.sv
// Ray and sphere nearest-hit unit.
// Input channel (in_*): a word with in_kind 0 loads a sphere into the next
// free table slot; in_kind 1 casts a ray against all stored spheres.
// Output channel (out_*): one result word per input word, in order.
// Configuration channel (cfg_*): writes the far limit max_distance; it is
// always ready and must only be used while the block is idle.
// A load goes straight to the done state; its result moves into the output
// register once that register is free. A cast visits the stored spheres one
// at a time through a sequencer around a single sphere table memory; each
// sphere passes the read, difference, multiply, sum, HB and discriminant states,
// then the bit-serial square root and root states if the discriminant is >= 0.
// One word is worked on at a time; in_stall is high from acceptance until
// its result has moved into the output register.
// The result stays in the output register while out_stall is high, and the
// next input word may already be accepted and processed during that time.
// Reset clears the sphere count, the far limit to 1000.0 and the output
// valid flag, and returns the sequencer to idle; the table is not cleared.
`default_nettype none

module nearest_sphere_hit_top import nsh_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_kind,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  input  wire logic [30:0]        in_radius,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [7:0]              out_hit_red,
  output logic [7:0]              out_hit_green,
  output logic [7:0]              out_hit_blue,
  output logic [30:0]             out_distance,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [30:0]        cfg_max_distance
);

  sphere_entry_t mem [SPHERE_SLOTS];
  sphere_entry_t mem_q_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] idx_r;
  logic [30:0] max_dist_r;

  logic signed [31:0] ox_r, oy_r, oz_r;
  logic signed [15:0] dx_r, dy_r, dz_r;

  logic signed [32:0] lx_r, ly_r, lz_r;
  logic [30:0] rad_r;
  logic [23:0] col_q_r;
  logic signed [48:0] px_r, py_r, pz_r;
  sq_parts_t sqx_r, sqy_r, sqz_r, sqr_r, sqh_r;
  logic signed [HB_W-1:0] hb_r;
  logic [DISC_W-1:0] neg_r, r2_r;

  logic [DISC_W-1:0] rad_bits_r;
  logic [ROOT_W+1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [SQ_CNT_W-1:0] sq_cnt_r;

  logic [30:0] best_r;
  logic found_r;
  logic [23:0] best_col_r;
  status_t res_status_r;

  logic out_valid_r;
  status_t out_status_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic [30:0] out_dist_r;

  logic in_acc, out_free, last_sphere, disc_ok, sq_last;
  logic signed [50:0] dot_sum;
  logic [DISC_W-1:0] pos_sum;
  logic [ROOT_W+1:0] rem_t, trial;
  logic signed [ROOT_W+2:0] t0, t1, t_sel;
  logic t_hit;

  always_comb begin
    in_acc      = in_valid && !in_stall;
    out_free    = !out_valid_r || !out_stall;
    last_sphere = (CNT_W'(idx_r) + 1'b1) == count_r;
    dot_sum     = 51'(px_r) + 51'(py_r) + 51'(pz_r);
    pos_sum     = sq_join(sqh_r) + r2_r;
    disc_ok     = pos_sum >= neg_r;
    sq_last     = sq_cnt_r == SQ_CNT_W'(ROOT_W - 1);
    rem_t       = {rem_r[ROOT_W-1:0], rad_bits_r[DISC_W-1 -: 2]};
    trial       = {root_r, 2'b01};
    t0          = -(ROOT_W+3)'(hb_r) - $signed({3'b000, root_r});
    t1          = -(ROOT_W+3)'(hb_r) + $signed({3'b000, root_r});
    t_sel       = t0[ROOT_W+2] ? t1 : t0;
    t_hit       = !t_sel[ROOT_W+2] && (t_sel < $signed({8'd0, best_r}));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_kind || count_r == '0) state_nxt = S_DONE;
          else state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_DIFF;
      S_DIFF: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_HB;
      S_HB:   state_nxt = S_DISC;
      S_DISC: begin
        if (disc_ok) state_nxt = S_SQRT;
        else if (last_sphere) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_SQRT: begin
        if (sq_last) state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (last_sphere) state_nxt = S_DONE;
        else state_nxt = S_READ;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state_r != S_IDLE;
    cfg_ready = 1'b1;
    out_valid      = out_valid_r;
    out_status     = out_status_r;
    out_hit_red    = out_red_r;
    out_hit_green  = out_green_r;
    out_hit_blue   = out_blue_r;
    out_distance   = out_dist_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc && !in_kind && count_r < CNT_W'(SPHERE_SLOTS)) begin
      mem[count_r[IDX_W-1:0]] <= '{cx: in_pos_x, cy: in_pos_y, cz: in_pos_z,
                                  rad: in_radius, red: in_red, green: in_green,
                                  blue: in_blue};
    end
    mem_q_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_dist_r  <= MAX_DISTANCE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) max_dist_r <= cfg_max_distance;
      if (state_r == S_IDLE && in_acc && !in_kind && count_r < CNT_W'(SPHERE_SLOTS)) begin
        count_r <= count_r + 1'b1;
      end
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        ox_r <= in_pos_x;
        oy_r <= in_pos_y;
        oz_r <= in_pos_z;
        dx_r <= in_dir_x;
        dy_r <= in_dir_y;
        dz_r <= in_dir_z;
        idx_r <= '0;
        best_r <= max_dist_r;
        found_r <= 1'b0;
        best_col_r <= '0;
        if (!in_kind) begin
          res_status_r <= (count_r < CNT_W'(SPHERE_SLOTS)) ? ST_LOADED : ST_FULL;
        end else begin
          res_status_r <= ST_MISS;
        end
      end
      S_DIFF: begin
        lx_r <= 33'(ox_r) - 33'(mem_q_r.cx);
        ly_r <= 33'(oy_r) - 33'(mem_q_r.cy);
        lz_r <= 33'(oz_r) - 33'(mem_q_r.cz);
        rad_r <= mem_q_r.rad;
        col_q_r <= {mem_q_r.red, mem_q_r.green, mem_q_r.blue};
      end
      S_MUL: begin
        px_r <= 49'(dx_r) * 49'(lx_r);
        py_r <= 49'(dy_r) * 49'(ly_r);
        pz_r <= 49'(dz_r) * 49'(lz_r);
        sqx_r <= sq_split(mag37(HB_W'(lx_r)));
        sqy_r <= sq_split(mag37(HB_W'(ly_r)));
        sqz_r <= sq_split(mag37(HB_W'(lz_r)));
        sqr_r <= sq_split({5'd0, rad_r});
      end
      S_SUM: begin
        hb_r  <= HB_W'(dot_sum >>> 14);
        neg_r <= sq_join(sqx_r) + sq_join(sqy_r) + sq_join(sqz_r);
        r2_r  <= sq_join(sqr_r);
      end
      S_HB: begin
        sqh_r <= sq_split(mag37(hb_r));
      end
      S_DISC: begin
        rad_bits_r <= pos_sum - neg_r;
        rem_r <= '0;
        root_r <= '0;
        sq_cnt_r <= '0;
        if (!disc_ok && !last_sphere) idx_r <= idx_r + 1'b1;
      end
      S_SQRT: begin
        rad_bits_r <= rad_bits_r << 2;
        sq_cnt_r <= sq_cnt_r + 1'b1;
        if (rem_t >= trial) begin
          rem_r <= rem_t - trial;
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_t;
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
      end
      S_ROOT: begin
        if (t_hit) begin
          best_r <= t_sel[30:0];
          found_r <= 1'b1;
          best_col_r <= col_q_r;
          res_status_r <= ST_HIT;
        end
        if (!last_sphere) idx_r <= idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_red_r    <= found_r ? best_col_r[23:16] : 8'd0;
      out_green_r  <= found_r ? best_col_r[15:8] : 8'd0;
      out_blue_r   <= found_r ? best_col_r[7:0] : 8'd0;
      out_dist_r   <= found_r ? best_r : 31'd0;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SPHERE_SLOTS))
    else $error("Sphere count exceeds the table size.");

  a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_kind && count_r < CNT_W'(SPHERE_SLOTS)) |=>
      count_r == $past(count_r) + 1'b1)
    else $error("Accepted load did not advance the sphere count.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_HIT) |->
      (out_dist_r == '0 && out_red_r == '0 && out_green_r == '0 && out_blue_r == '0))
    else $error("Non-hit result carries color or distance.");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT |-> sq_cnt_r < SQ_CNT_W'(ROOT_W))
    else $error("Square root ran past its last step.");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> CNT_W'(idx_r) < count_r)
    else $error("Scan reads beyond the stored spheres.");
`endif

endmodule

`default_nettype wire

FILE: sim/nsh_result_checker.sv
`timescale 1ns / 100ps

module nsh_result_checker import nsh_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic               in_kind,
  input  wire logic signed [31:0] in_pos_x,
  input  wire logic signed [31:0] in_pos_y,
  input  wire logic signed [31:0] in_pos_z,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  input  wire logic [30:0]        in_radius,
  input  wire logic [7:0]         in_red,
  input  wire logic [7:0]         in_green,
  input  wire logic [7:0]         in_blue,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         out_status,
  input  wire logic [7:0]         out_hit_red,
  input  wire logic [7:0]         out_hit_green,
  input  wire logic [7:0]         out_hit_blue,
  input  wire logic [30:0]        out_distance,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [30:0]        cfg_max_distance,
  output int                      fail_count,
  output int                      pending
);

  typedef struct {
    status_t     status;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [30:0] distance;
  } hit_word_t;

  logic signed [31:0] ctr_x [SPHERE_SLOTS];
  logic signed [31:0] ctr_y [SPHERE_SLOTS];
  logic signed [31:0] ctr_z [SPHERE_SLOTS];
  logic [30:0]        rad   [SPHERE_SLOTS];
  logic [23:0]        color [SPHERE_SLOTS];
  int                 stored;
  logic [30:0]        far_limit;
  hit_word_t          expected_hits [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [47:0] floor_sqrt(input logic [127:0] v);
    logic [47:0] res;
    logic [47:0] cand;
    res = '0;
    for (int b = 47; b >= 0; b--) begin
      cand = res | (48'd1 << b);
      if (128'(cand) * 128'(cand) <= v) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic bit sphere_root(input int k, input longint ox, oy, oz,
                                     input longint dx, dy, dz, output longint t);
    longint lx, ly, lz, dot, hb, s, t0, t1;
    logic [127:0] pos, neg;
    lx = ox - longint'(ctr_x[k]);
    ly = oy - longint'(ctr_y[k]);
    lz = oz - longint'(ctr_z[k]);
    dot = dx * lx + dy * ly + dz * lz;
    hb = dot >>> 14;
    pos = 128'(abs64(hb)) * 128'(abs64(hb)) + 128'(rad[k]) * 128'(rad[k]);
    neg = 128'(abs64(lx)) * 128'(abs64(lx)) + 128'(abs64(ly)) * 128'(abs64(ly))
        + 128'(abs64(lz)) * 128'(abs64(lz));
    t = 0;
    if (pos < neg) return 0;
    s = longint'(floor_sqrt(pos - neg));
    t0 = -hb - s;
    t1 = -hb + s;
    if (t0 >= 0) begin
      t = t0;
      return 1;
    end
    if (t1 >= 0) begin
      t = t1;
      return 1;
    end
    return 0;
  endfunction

  function automatic hit_word_t predict_word();
    hit_word_t w;
    longint best, t;
    w = '{ST_LOADED, 8'd0, 8'd0, 8'd0, 31'd0};
    if (!in_kind) begin
      if (stored >= SPHERE_SLOTS) begin
        w.status = ST_FULL;
      end else begin
        ctr_x[stored] = in_pos_x;
        ctr_y[stored] = in_pos_y;
        ctr_z[stored] = in_pos_z;
        rad[stored] = in_radius;
        color[stored] = {in_red, in_green, in_blue};
        stored++;
      end
      return w;
    end
    best = longint'(far_limit);
    w.status = ST_MISS;
    for (int k = 0; k < stored; k++) begin
      if (sphere_root(k, in_pos_x, in_pos_y, in_pos_z, in_dir_x, in_dir_y,
                      in_dir_z, t) && t < best) begin
        best = t;
        w.status = ST_HIT;
        {w.red, w.green, w.blue} = color[k];
        w.distance = best[30:0];
      end
    end
    return w;
  endfunction

  function automatic int field_ok(string name, logic [30:0] exp_v, logic [30:0] got_v);
    if (exp_v === got_v) return 1;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    return 0;
  endfunction

  always @(posedge clk) begin
    hit_word_t w;
    int ok;
    if (!rst_n) begin
      stored = 0;
      far_limit = MAX_DISTANCE_RESET;
      expected_hits.delete();
    end else begin
      if (cfg_valid && cfg_ready) far_limit = cfg_max_distance;
      if (out_valid && !out_stall) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: result word with nothing expected, status %0d", $time,
                   out_status);
          fail_count <= fail_count + 1;
        end else begin
          w = expected_hits.pop_front();
          ok = field_ok("status", 31'(w.status), 31'(out_status))
             & field_ok("hit_red", 31'(w.red), 31'(out_hit_red))
             & field_ok("hit_green", 31'(w.green), 31'(out_hit_green))
             & field_ok("hit_blue", 31'(w.blue), 31'(out_hit_blue))
             & field_ok("distance", w.distance, out_distance);
          if (!ok) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && !in_stall) expected_hits.push_back(predict_word());
    end
    pending <= expected_hits.size();
  end

endmodule

FILE: sim/tb_nearest_sphere_hit_top.sv
`timescale 1ns / 100ps

module tb_nearest_sphere_hit_top;
  import nsh_pkg::*;

  localparam int CYCLE_LIMIT = 8000000;
  localparam int UNIT = 65536;

  typedef struct {
    logic               kind;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] dx, dy, dz;
    logic [30:0]        rad;
    logic [7:0]         r, g, b;
  } word_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_kind = 1'b0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic [30:0]        in_radius = '0;
  logic [7:0]         in_red = '0, in_green = '0, in_blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [7:0]         out_hit_red, out_hit_green, out_hit_blue;
  logic [30:0]        out_distance;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [30:0]        cfg_max_distance = '0;
  int                 fail_count, pending;
  int                 cycles = 0;
  int                 stall_left = 0;
  int                 burst_left = 0;
  int                 loads = 0;
  int                 aim_x [64], aim_y [64], aim_z [64];

  nearest_sphere_hit_top uut (.*);

  nsh_result_checker result_chk (.*);

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_nearest_sphere_hit_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      if (out_stall) begin
        out_stall <= 1'b0;
        stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(0, 8);
      end else begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 12);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  task automatic send_word(input word_t w);
    in_valid <= 1'b1;
    in_kind <= w.kind;
    in_pos_x <= w.px;
    in_pos_y <= w.py;
    in_pos_z <= w.pz;
    in_dir_x <= w.dx;
    in_dir_y <= w.dy;
    in_dir_z <= w.dz;
    in_radius <= w.rad;
    in_red <= w.r;
    in_green <= w.g;
    in_blue <= w.b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!w.kind) begin
      if (loads < 64) begin
        aim_x[loads] = w.px;
        aim_y[loads] = w.py;
        aim_z[loads] = w.pz;
      end
      loads++;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_far_limit(input logic [30:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_max_distance <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic word_t sphere_word(int x, int y, int z, logic [30:0] rad,
                                        logic [23:0] rgb);
    word_t w;
    w = '{1'b0, x, y, z, 16'sd0, 16'sd0, 16'sd0, rad, rgb[23:16], rgb[15:8], rgb[7:0]};
    return w;
  endfunction

  function automatic word_t ray_word(int x, int y, int z, int dx, int dy, int dz);
    word_t w;
    w = '{1'b1, x, y, z, 16'(dx), 16'(dy), 16'(dz), 31'd0, 8'd0, 8'd0, 8'd0};
    return w;
  endfunction

  function automatic int near_coord(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic word_t random_word();
    word_t w;
    int k;
    int ox, oy, oz;
    real vx, vy, vz, len;
    bit tidy;
    tidy = $urandom_range(0, 4) != 0;
    w.r = 8'($urandom);
    w.g = 8'($urandom);
    w.b = 8'($urandom);
    w.rad = 31'(tidy ? $urandom_range(UNIT / 2, 8 * UNIT) : $urandom);
    w.dx = 16'(int'($urandom_range(0, 32768)) - 16384);
    w.dy = 16'(int'($urandom_range(0, 32768)) - 16384);
    w.dz = 16'(int'($urandom_range(0, 32768)) - 16384);
    if (tidy) begin
      w.px = near_coord(32 * UNIT);
      w.py = near_coord(32 * UNIT);
      w.pz = near_coord(32 * UNIT);
    end else begin
      w.px = $urandom;
      w.py = $urandom;
      w.pz = $urandom;
    end
    w.kind = !(loads == 0 || $urandom_range(0, 7) == 0);
    if (w.kind && tidy) begin
      k = $urandom_range(0, ((loads < 64) ? loads : 64) - 1);
      ox = aim_x[k] + near_coord(48 * UNIT);
      oy = aim_y[k] + near_coord(48 * UNIT);
      oz = aim_z[k] + near_coord(48 * UNIT);
      vx = real'(aim_x[k] + near_coord(2 * UNIT) - ox);
      vy = real'(aim_y[k] + near_coord(2 * UNIT) - oy);
      vz = real'(aim_z[k] + near_coord(2 * UNIT) - oz);
      len = $sqrt(vx * vx + vy * vy + vz * vz);
      w.px = ox;
      w.py = oy;
      w.pz = oz;
      if (len > 1.0) begin
        w.dx = 16'($rtoi(vx / len * 16384.0));
        w.dy = 16'($rtoi(vy / len * 16384.0));
        w.dz = 16'($rtoi(vz / len * 16384.0));
      end
    end
    return w;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(ray_word(0, 0, -5 * UNIT, 0, 0, 16384));
    send_word(sphere_word(0, 0, 0, UNIT, 24'hFF0000));
    send_word(ray_word(0, 0, -5 * UNIT, 0, 0, 16384));
    send_word(ray_word(0, 0, 0, 16384, 0, 0));
    send_word(ray_word(0, 0, 5 * UNIT, 0, 0, 16384));
    send_word(ray_word(UNIT, 0, -5 * UNIT, 0, 0, 16384));
    send_word(sphere_word(0, 0, 0, UNIT, 24'h00FF00));
    send_word(ray_word(0, 0, -9 * UNIT, 0, 0, 16384));
    send_word(ray_word(-3 * UNIT, -3 * UNIT, 0, 16384, 16384, 0));
    send_word(ray_word(0, 0, -5 * UNIT, -16384, -16384, -16384));
    send_word(sphere_word(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF,
                          24'h0000FF));
    send_word(sphere_word(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 31'd0,
                          24'hFFFFFF));
    send_word(ray_word(32'sh80000000, 32'sh80000000, 32'sh80000000, 16384, 16384, 16384));
    send_word(ray_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -16384, 0, 16384));
    send_word(ray_word(0, 0, -20 * UNIT, 0, 0, 16384));

    write_far_limit(31'd0);
    send_word(ray_word(0, 0, -5 * UNIT, 0, 0, 16384));
    repeat (30) send_word(random_word());

    write_far_limit(31'h7FFFFFFF);
    send_word(ray_word(0, 0, -5 * UNIT, 0, 0, 16384));
    repeat (150) send_word(random_word());

    write_far_limit(4 * UNIT);
    send_word(ray_word(0, 0, -5 * UNIT, 0, 0, 16384));
    send_word(ray_word(0, 0, -5 * UNIT - 1, 0, 0, 16384));
    repeat (150) send_word(random_word());

    write_far_limit(31'($urandom_range(1, 40 * UNIT)));
    repeat (120) send_word(random_word());

    write_far_limit(MAX_DISTANCE_RESET);
    repeat (120) send_word(random_word());
    while (loads < 68) send_word(sphere_word(near_coord(32 * UNIT), near_coord(32 * UNIT),
                                             near_coord(32 * UNIT), 2 * UNIT, 24'h123456));
    repeat (10) send_word(random_word());

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_nearest_sphere_hit_top: PASS");
    end else begin
      $display("tb_nearest_sphere_hit_top: FAIL");
    end
    $finish;
  end

endmodule
